// ----- rtl/vpa_pkg.sv -----
// Shared types and codes for the variable partition allocator.
`default_nettype none
package vpa_pkg;

  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

  // Table operations issued by the controller to the datapath.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_TAKE,
    OP_CLEAR,
    OP_SPLIT,
    OP_MERGE
  } vpa_op_e;

endpackage
`default_nettype wire

// ----- rtl/vpa_if.sv -----
// Request and response channel interfaces of the allocator.
`default_nettype none
interface vpa_req_if
  import vpa_pkg::*;
#(
  parameter int LEN_W = 11
);
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [OWNER_W-1:0] owner_id;
  logic [LEN_W-1:0]   alloc_size;

  modport source (output valid, cmd, owner_id, alloc_size, input ready);
  modport sink   (input valid, cmd, owner_id, alloc_size, output ready);
endinterface

interface vpa_rsp_if
  import vpa_pkg::*;
#(
  parameter int ADDR_W = 10,
  parameter int LEN_W  = 11
);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   start_addr;
  logic [LEN_W-1:0]    seg_size;

  modport source (output valid, status, start_addr, seg_size, input ready);
  modport sink   (input valid, status, start_addr, seg_size, output ready);
endinterface
`default_nettype wire

// ----- rtl/variable_partition_allocator.sv -----
// Top level of the variable partition allocator.
//
// The block manages an address-ordered table of segments covering MEM_UNITS
// units. Requests arrive on req_i: an allocate (cmd 0) asks for alloc_size
// units for owner_id, a free (cmd 1) releases the owner's lowest segment and
// merges it with free neighbors. Every request returns one word on rsp_o
// with a status, the segment start and the segment size.
// The placement rule is set through cfg_we_i / cfg_wdata_i: first, next or
// best fit. Write it only while no request is in flight.
// One request is handled at a time. The scan reads the table one entry at a
// time through the single registered read port, with a read state and an
// evaluate state per entry.
// Splits and merges shift the table in place.
// Reset returns the table to one free segment spanning the whole memory,
// first fit, rover at entry zero; it takes effect at once.
// The response sits in an output register; a new request is accepted while
// it waits, but the following response is held until the receiver takes it.
`default_nettype none
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32,
  parameter int MEM_UNITS    = 1024
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [MODE_W-1:0] cfg_wdata_i,
  vpa_req_if.sink          req_i,
  vpa_rsp_if.source        rsp_o
);

  localparam int ADDR_W = $clog2(MEM_UNITS);
  localparam int LEN_W  = $clog2(MEM_UNITS + 1);
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CMD_W  = 3 + 2 * IDX_W + LEN_W + OWNER_W;
  localparam int STAT_W = ADDR_W + LEN_W + OWNER_W + 2;

  logic [CMD_W-1:0]  dp_cmd;
  logic [STAT_W-1:0] dp_stat;

  vpa_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .MEM_UNITS   (MEM_UNITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .cmd_o      (dp_cmd),
    .stat_i     (dp_stat)
  );

  vpa_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .MEM_UNITS   (MEM_UNITS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (dp_cmd),
    .stat_o(dp_stat)
  );

endmodule
`default_nettype wire

// ----- rtl/vpa_datapath.sv -----
// Segment table with one registered read port and in-place split and merge.
`default_nettype none
module vpa_datapath
  import vpa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32,
  parameter int MEM_UNITS    = 1024
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  [$clog2(MAX_SEGMENTS)+$clog2(MEM_UNITS+1)+OWNER_W+3+$clog2(MAX_SEGMENTS)-1:0]
               cmd_i,
  output logic [$clog2(MEM_UNITS)+$clog2(MEM_UNITS+1)+OWNER_W+1:0] stat_o
);

  localparam int ADDR_W = $clog2(MEM_UNITS);
  localparam int LEN_W  = $clog2(MEM_UNITS + 1);
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   len;
    logic [OWNER_W-1:0] owner;
    logic               used;
  } entry_t;

  typedef struct packed {
    vpa_op_e            op;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [LEN_W-1:0]   size;
    logic [OWNER_W-1:0] owner;
  } dp_cmd_t;

  typedef struct packed {
    entry_t rd;
    logic   sv_used;
  } dp_stat_t;

  dp_cmd_t cmd;
  entry_t  tab_q [MAX_SEGMENTS];
  entry_t  rd_q;
  entry_t  sv_q;

  assign cmd    = cmd_i;
  assign stat_o = {rd_q, sv_q.used};

  always_ff @(posedge clk_i) begin
    rd_q <= tab_q[cmd.rd_idx];
    if (cmd.op == OP_LATCH) begin
      sv_q <= rd_q;
    end
  end

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_ent
    entry_t below;
    entry_t above;
    if (g > 0) begin : g_b
      assign below = tab_q[g-1];
    end else begin : g_nb
      assign below = '0;
    end
    if (g < MAX_SEGMENTS - 1) begin : g_a
      assign above = tab_q[g+1];
    end else begin : g_na
      assign above = tab_q[g];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        if (g == 0) begin
          tab_q[g] <= '{start: '0, len: LEN_W'(MEM_UNITS), owner: '0, used: 1'b0};
        end else begin
          tab_q[g] <= '0;
        end
      end else begin
        case (cmd.op)
          OP_TAKE: begin
            if (g == int'(cmd.idx)) begin
              tab_q[g].used  <= 1'b1;
              tab_q[g].owner <= cmd.owner;
            end
          end
          OP_CLEAR: begin
            if (g == int'(cmd.idx)) begin
              tab_q[g].used  <= 1'b0;
              tab_q[g].owner <= '0;
            end
          end
          OP_SPLIT: begin
            if (g == int'(cmd.idx)) begin
              tab_q[g].len   <= cmd.size;
              tab_q[g].owner <= cmd.owner;
              tab_q[g].used  <= 1'b1;
            end else if (g == int'(cmd.idx) + 1) begin
              tab_q[g].start <= rd_q.start + ADDR_W'(cmd.size);
              tab_q[g].len   <= rd_q.len - cmd.size;
              tab_q[g].owner <= '0;
              tab_q[g].used  <= 1'b0;
            end else if (g > int'(cmd.idx) + 1) begin
              tab_q[g] <= below;
            end
          end
          OP_MERGE: begin
            // The saved word is the lower neighbor, the read word the upper one.
            if (g + 1 == int'(cmd.idx)) begin
              tab_q[g].len   <= sv_q.len + rd_q.len;
              tab_q[g].owner <= '0;
              tab_q[g].used  <= 1'b0;
            end else if (g >= int'(cmd.idx)) begin
              tab_q[g] <= above;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vpa_ctrl.sv -----
// Controller that sequences table scans, splits and merges for each request.
`default_nettype none
module vpa_ctrl
  import vpa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 32,
  parameter int MEM_UNITS    = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [MODE_W-1:0] cfg_wdata_i,
  vpa_req_if.sink     req_i,
  vpa_rsp_if.source   rsp_o,
  output logic [$clog2(MAX_SEGMENTS)+$clog2(MEM_UNITS+1)+OWNER_W+3+$clog2(MAX_SEGMENTS)-1:0]
               cmd_o,
  input  wire  [$clog2(MEM_UNITS)+$clog2(MEM_UNITS+1)+OWNER_W+1:0] stat_i
);

  localparam int ADDR_W = $clog2(MEM_UNITS);
  localparam int LEN_W  = $clog2(MEM_UNITS + 1);
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   len;
    logic [OWNER_W-1:0] owner;
    logic               used;
  } entry_t;

  typedef struct packed {
    vpa_op_e            op;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [LEN_W-1:0]   size;
    logic [OWNER_W-1:0] owner;
  } dp_cmd_t;

  typedef struct packed {
    entry_t rd;
    logic   sv_used;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SEV, S_ARD, S_ADO,
    S_FR1, S_FL1, S_FM1, S_FR2, S_FL2, S_FM2, S_PUT
  } state_e;

  state_e              state_q;
  logic [MODE_W-1:0]   mode_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    rover_q;
  logic [CNT_W-1:0]    k_q;
  logic [IDX_W-1:0]    i_q;
  logic [IDX_W-1:0]    c_q;
  logic                found_q;
  logic [LEN_W-1:0]    best_q;
  logic                cmd_q;
  logic [OWNER_W-1:0]  own_q;
  logic [LEN_W-1:0]    sz_q;
  logic [STATUS_W-1:0] res_st_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic [LEN_W-1:0]    res_len_q;
  logic                ov_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [LEN_W-1:0]    out_len_q;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     fits;
  logic     match;
  logic     last;
  logic     better;
  logic [IDX_W-1:0] i_nxt;
  logic [IDX_W-1:0] c_up;
  logic [IDX_W-1:0] c_dn;
  logic             has_up;

  assign st     = stat_i;
  assign cmd_o  = cmd;
  assign fits   = !st.rd.used && (st.rd.len >= sz_q);
  assign match  = st.rd.used && (st.rd.owner == own_q);
  assign last   = (k_q + CNT_W'(1)) == cnt_q;
  assign better = fits && (!found_q || st.rd.len < best_q);
  assign i_nxt  = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_q) ? '0 : i_q + IDX_W'(1);
  assign c_up   = c_q + IDX_W'(1);
  assign c_dn   = c_q - IDX_W'(1);
  assign has_up = (CNT_W'(c_q) + CNT_W'(1)) < cnt_q;

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = ov_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.start_addr = out_addr_q;
  assign rsp_o.seg_size   = out_len_q;

  always_comb begin
    cmd.op     = OP_NOP;
    cmd.idx    = c_q;
    cmd.rd_idx = i_q;
    cmd.size   = sz_q;
    cmd.owner  = own_q;
    unique case (state_q)
      S_SEV: begin
        if (cmd_q == CMD_FREE && match) begin
          cmd.op  = OP_CLEAR;
          cmd.idx = i_q;
        end
      end
      S_ARD: cmd.rd_idx = c_q;
      S_ADO: begin
        if (st.rd.len == sz_q) begin
          cmd.op = OP_TAKE;
        end else if (cnt_q < CNT_W'(MAX_SEGMENTS)) begin
          cmd.op = OP_SPLIT;
        end
      end
      S_FR1: cmd.rd_idx = c_q;
      S_FL1: begin
        cmd.op     = OP_LATCH;
        cmd.rd_idx = c_up;
      end
      S_FM1: begin
        if (!st.rd.used) begin
          cmd.op  = OP_MERGE;
          cmd.idx = c_up;
        end
      end
      S_FR2: cmd.rd_idx = c_dn;
      S_FL2: begin
        cmd.op     = OP_LATCH;
        cmd.rd_idx = c_q;
      end
      S_FM2: begin
        if (!st.sv_used) begin
          cmd.op = OP_MERGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_FIRST;
      cnt_q   <= CNT_W'(1);
      rover_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      // In S_PUT the output register is handled by the state itself.
      if (ov_q && rsp_o.ready && state_q != S_PUT) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            cmd_q      <= req_i.cmd;
            own_q      <= req_i.owner_id;
            sz_q       <= req_i.alloc_size;
            k_q        <= '0;
            found_q    <= 1'b0;
            res_st_q   <= ST_OK;
            res_addr_q <= '0;
            res_len_q  <= '0;
            // Only a next-fit allocate starts at the rover; a free always scans from zero.
            if (req_i.cmd == CMD_ALLOC && mode_q == MODE_NEXT && CNT_W'(rover_q) < cnt_q) begin
              i_q <= rover_q;
            end else begin
              i_q <= '0;
            end
            if (req_i.cmd == CMD_ALLOC && req_i.alloc_size == '0) begin
              res_st_q <= ST_NO_FIT;
              state_q  <= S_PUT;
            end else begin
              state_q <= S_SRD;
            end
          end
        end
        S_SRD: state_q <= S_SEV;
        S_SEV: begin
          k_q     <= k_q + CNT_W'(1);
          i_q     <= i_nxt;
          state_q <= S_SRD;
          if (cmd_q == CMD_FREE) begin
            if (match) begin
              c_q        <= i_q;
              res_addr_q <= st.rd.start;
              res_len_q  <= st.rd.len;
              state_q    <= S_FR1;
            end else if (last) begin
              res_st_q <= ST_NO_OWNER;
              state_q  <= S_PUT;
            end
          end else if (mode_q == MODE_BEST) begin
            if (better) begin
              c_q     <= i_q;
              found_q <= 1'b1;
              best_q  <= st.rd.len;
            end
            if (last) begin
              if (found_q || better) begin
                state_q <= S_ARD;
              end else begin
                res_st_q <= ST_NO_FIT;
                state_q  <= S_PUT;
              end
            end
          end else begin
            if (fits) begin
              c_q     <= i_q;
              state_q <= S_ARD;
            end else if (last) begin
              res_st_q <= ST_NO_FIT;
              state_q  <= S_PUT;
            end
          end
        end
        S_ARD: state_q <= S_ADO;
        S_ADO: begin
          state_q <= S_PUT;
          if (st.rd.len == sz_q) begin
            res_addr_q <= st.rd.start;
            res_len_q  <= sz_q;
            if (mode_q == MODE_NEXT) begin
              rover_q <= c_q;
            end
          end else if (cnt_q >= CNT_W'(MAX_SEGMENTS)) begin
            res_st_q <= ST_FULL;
          end else begin
            res_addr_q <= st.rd.start;
            res_len_q  <= sz_q;
            cnt_q      <= cnt_q + CNT_W'(1);
            if (mode_q == MODE_NEXT) begin
              rover_q <= c_q;
            end else if (rover_q >= c_q) begin
              rover_q <= rover_q + IDX_W'(1);
            end
          end
        end
        S_FR1: state_q <= has_up ? S_FL1 : S_FR2;
        S_FL1: state_q <= S_FM1;
        S_FM1: begin
          if (!st.rd.used) begin
            cnt_q <= cnt_q - CNT_W'(1);
            if (rover_q >= c_up) begin
              rover_q <= rover_q - IDX_W'(1);
            end
          end
          state_q <= S_FR2;
        end
        S_FR2: state_q <= (c_q != '0) ? S_FL2 : S_PUT;
        S_FL2: state_q <= S_FM2;
        S_FM2: begin
          if (!st.sv_used) begin
            cnt_q <= cnt_q - CNT_W'(1);
            if (rover_q >= c_q) begin
              rover_q <= rover_q - IDX_W'(1);
            end
          end
          state_q <= S_PUT;
        end
        S_PUT: begin
          if (!ov_q || rsp_o.ready) begin
            ov_q       <= 1'b1;
            out_st_q   <= res_st_q;
            out_addr_q <= res_addr_q;
            out_len_q  <= res_len_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vpa_checker.sv -----
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
module vpa_checker
  import vpa_pkg::*;
#(
  parameter int ADDR_W = 10,
  parameter int LEN_W  = 11
) (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_i,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input wire [STATUS_W-1:0] out_status_i,
  input wire [ADDR_W-1:0]   out_addr_i,
  input wire [LEN_W-1:0]    out_size_i
);

  // A waiting response word is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response word dropped while stalled");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in flight");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_addr_i == '0 && out_size_i == '0)
    else $error("failed request reports a segment");

  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_OK |-> out_size_i != '0)
    else $error("successful request reports an empty segment");

endmodule

bind variable_partition_allocator vpa_checker #(
  .ADDR_W(ADDR_W),
  .LEN_W (LEN_W)
) u_vpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_status_i(rsp_o.status),
  .out_addr_i  (rsp_o.start_addr),
  .out_size_i  (rsp_o.seg_size)
);
`default_nettype wire
